>>> rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared types and codes for the indexed list store
// Request and response beats, request and status codes, and the control
// word that the top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ils_pkg;

	// Wide enough for any list position or entry count up to 256 entries.
	localparam int IDX_W = 9;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_GET    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [4:0]         position;
		logic signed [31:0] word_in;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] word_out;
		logic [4:0]         entry_count;
		logic               is_empty;
	} rsp_t;

	typedef struct packed {
		logic               ins_en;
		logic               rem_en;
		logic [IDX_W-1:0]   pos;
		logic [IDX_W-1:0]   cnt;
		logic signed [31:0] word;
	} cell_ctrl_t;

endpackage

>>> rtl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell: one storage cell of the list
// Holds a single entry. On an insert it takes its left neighbour's word (or
// the new word at the target position); on a remove it takes its right
// neighbour's word. It also offers its word for a read at its own position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ils_cell
	import ils_pkg::*;
(
	input  logic               clk,
	input  logic [IDX_W-1:0]   idx,
	input  cell_ctrl_t         ctrl,
	input  logic signed [31:0] left_word,
	input  logic signed [31:0] right_word,
	output logic signed [31:0] word,
	output logic signed [31:0] rd_word
);

	logic signed [31:0] word_q;
	logic               at_pos;
	logic               above_pos;
	logic               below_cnt;
	logic               below_last;

	assign at_pos     = (idx == ctrl.pos);
	assign above_pos  = (idx > ctrl.pos);
	assign below_cnt  = (idx <= ctrl.cnt);
	// True when idx + 1 < cnt, so that a right neighbour holds a live entry.
	assign below_last = (({1'b0, idx} + {{IDX_W{1'b0}}, 1'b1}) < {1'b0, ctrl.cnt});

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (at_pos) begin
				word_q <= ctrl.word;
			end else if (above_pos && below_cnt) begin
				word_q <= left_word;
			end
		end else if (ctrl.rem_en) begin
			if ((at_pos || above_pos) && below_last) begin
				word_q <= right_word;
			end
		end
	end

	assign word    = word_q;
	assign rd_word = at_pos ? word_q : 32'sd0;

endmodule

>>> rtl/indexed_list_store_core.sv
// ----------------------------------------------------------------------------
// indexed_list_store_core: bounded ordered list of signed 32-bit words
// A response beat appears, registered, in the cycle after its request is taken.
// One request per cycle unless out_ready stalls; affected cells shift on accept.
// Reset clears the entry count and the response valid; cell contents are
// left as they are and are only read below the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_store_core
	import ils_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nx;
	logic               out_valid_q;
	rsp_t               out_data_q;
	logic               accept;
	logic [IDX_W-1:0]   pos_x;
	logic [IDX_W-1:0]   cnt_x;
	logic               ins_ok;
	logic               rem_ok;
	logic               get_ok;
	logic [1:0]         status;
	logic signed [31:0] rd_or;
	cell_ctrl_t         ctrl;

	logic signed [31:0] cell_word [CAPACITY];
	logic signed [31:0] cell_rd   [CAPACITY];

	// A new request may enter whenever the response register is free or
	// is being emptied in the same cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign pos_x = {{(IDX_W-5){1'b0}}, in_data.position};
	assign cnt_x = IDX_W'(count_q);

	always_comb begin
		ins_ok = 1'b0;
		rem_ok = 1'b0;
		get_ok = 1'b0;
		status = ST_OK;
		case (in_data.req_type)
			REQ_INSERT: begin
				if (pos_x > cnt_x) begin
					status = ST_RANGE;
				end else if (cnt_x >= IDX_W'(CAPACITY)) begin
					status = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			REQ_GET: begin
				if (pos_x >= cnt_x) begin
					status = ST_RANGE;
				end else begin
					get_ok = 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (pos_x >= cnt_x) begin
					status = ST_RANGE;
				end else begin
					rem_ok = 1'b1;
				end
			end
			default: begin
				status = ST_RANGE;
			end
		endcase
	end

	always_comb begin
		count_nx = count_q;
		if (ins_ok) begin
			count_nx = count_q + CNT_W'(1);
		end else if (rem_ok) begin
			count_nx = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		ctrl.ins_en = accept && ins_ok;
		ctrl.rem_en = accept && rem_ok;
		ctrl.pos    = pos_x;
		ctrl.cnt    = cnt_x;
		ctrl.word   = in_data.word_in;
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic signed [31:0] left_w;
			logic signed [31:0] right_w;
			if (gi == 0) begin : g_first
				assign left_w = 32'sd0;
			end else begin : g_mid_l
				assign left_w = cell_word[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_w = 32'sd0;
			end else begin : g_mid_r
				assign right_w = cell_word[gi+1];
			end
			ils_cell u_cell (
				.clk        (clk),
				.idx        (IDX_W'(gi)),
				.ctrl       (ctrl),
				.left_word  (left_w),
				.right_word (right_w),
				.word       (cell_word[gi]),
				.rd_word    (cell_rd[gi])
			);
		end
	endgenerate

	// Only the cell at the requested position offers a non-zero word.
	always_comb begin
		rd_or = 32'sd0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q.status      <= status;
			out_data_q.word_out    <= get_ok ? rd_or : 32'sd0;
			out_data_q.entry_count <= 5'(count_nx);
			out_data_q.is_empty    <= (count_nx == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the indexed list store
// A queued driver and a clocked monitor exercise insert, get and remove with
// random idle gaps on both channels. Every response beat is checked field by
// field against a list predictor that is updated as each request is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import ils_pkg::*;

	localparam int LIST_CAP = 16;
	localparam int RANDOM_ITEMS = 730;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_IDLE = 12;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	// Pending request beats and the responses they are predicted to produce.
	req_t request_q[$];
	rsp_t awaited_rsp_q[$];

	// Predictor copy of the list.
	logic signed [31:0] list_words [LIST_CAP];
	int list_len = 0;
	int peak_len = 0;

	// Entry count as the generator sees it, so positions can be aimed in range.
	int gen_len = 0;

	int err_cnt = 0;
	int cycle_cnt = 0;
	int accepted_cnt = 0;
	int checked_cnt = 0;
	int status_seen [4] = '{default: 0};

	int drv_idle = 0;
	int drv_calm = 0;
	int mon_idle = 0;
	int mon_calm = 0;

	indexed_list_store_core #(
		.CAPACITY(LIST_CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR at %0t ns: %s is %0h, expected %0h", $time, field, got, want);
		err_cnt++;
	endtask

	// Applies one accepted request to the list copy and returns its response.
	function automatic rsp_t list_apply(input req_t rq);
		rsp_t rs;
		int i;
		int p;
		rs = '0;
		rs.status = ST_OK;
		p = int'(rq.position);
		case (rq.req_type)
			REQ_INSERT: begin
				if (p > list_len) begin
					rs.status = ST_RANGE;
				end else if (list_len >= LIST_CAP) begin
					rs.status = ST_FULL;
				end else begin
					for (i = list_len; i > p; i--)
						list_words[i] = list_words[i-1];
					list_words[p] = rq.word_in;
					list_len++;
				end
			end
			REQ_GET: begin
				if (p >= list_len)
					rs.status = ST_RANGE;
				else
					rs.word_out = list_words[p];
			end
			REQ_REMOVE: begin
				if (p >= list_len) begin
					rs.status = ST_RANGE;
				end else begin
					for (i = p; i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
				end
			end
			default: rs.status = ST_RANGE;
		endcase
		rs.entry_count = list_len[4:0];
		rs.is_empty = (list_len == 0);
		if (list_len > peak_len)
			peak_len = list_len;
		return rs;
	endfunction

	// Queues a request and tracks the entry count it will leave behind.
	task automatic queue_request(input logic [1:0] kind, input logic [4:0] pos,
			input logic [31:0] word);
		req_t rq;
		rq.req_type = kind;
		rq.position = pos;
		rq.word_in = word;
		request_q.push_back(rq);
		if (kind == REQ_INSERT && int'(pos) <= gen_len && gen_len < LIST_CAP)
			gen_len++;
		else if (kind == REQ_REMOVE && int'(pos) < gen_len)
			gen_len--;
	endtask

	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 15))
			0: w = 32'h8000_0000;
			1: w = 32'h7fff_ffff;
			2: w = 32'hffff_ffff;
			3: w = 32'h0000_0000;
			default: ;
		endcase
		return w;
	endfunction

	// Mostly aims at a live position; the rest lands anywhere in the field.
	function automatic logic [4:0] pick_position(input logic [1:0] kind);
		logic [4:0] p;
		p = 5'($urandom_range(0, 31));
		if ($urandom_range(0, 99) < 85) begin
			if (kind == REQ_INSERT)
				p = 5'($urandom_range(0, gen_len));
			else if (gen_len > 0)
				p = 5'($urandom_range(0, gen_len - 1));
		end
		return p;
	endfunction

	initial begin
		int seg_kind;
		int roll;
		logic [1:0] kind;

		// Directed requests: empty list, both ends, the middle and the errors.
		queue_request(REQ_GET, 5'd0, 32'h0);
		queue_request(REQ_REMOVE, 5'd0, 32'h0);
		queue_request(REQ_REMOVE, 5'd31, 32'hffff_ffff);
		queue_request(REQ_INSERT, 5'd1, 32'h1111_1111);
		queue_request(REQ_UNUSED, 5'd0, 32'h0);
		queue_request(REQ_INSERT, 5'd0, 32'h8000_0000);
		queue_request(REQ_INSERT, 5'd1, 32'h7fff_ffff);
		queue_request(REQ_INSERT, 5'd0, 32'hffff_ffff);
		queue_request(REQ_INSERT, 5'd1, 32'h0000_0000);
		queue_request(REQ_INSERT, 5'd31, 32'h5555_5555);
		queue_request(REQ_GET, 5'd0, 32'haaaa_aaaa);
		queue_request(REQ_GET, 5'd3, 32'h0);
		queue_request(REQ_GET, 5'd4, 32'h0);
		queue_request(REQ_GET, 5'd31, 32'h0);
		queue_request(REQ_REMOVE, 5'd1, 32'h0);
		queue_request(REQ_REMOVE, 5'd2, 32'h0);
		queue_request(REQ_REMOVE, 5'd0, 32'h0);
		queue_request(REQ_GET, 5'd0, 32'h0);
		queue_request(REQ_UNUSED, 5'd31, 32'hffff_ffff);
		queue_request(REQ_REMOVE, 5'd0, 32'h0);
		queue_request(REQ_INSERT, 5'd0, 32'h1234_5678);

		// Random requests in segments that fill, drain or mix the list.
		seg_kind = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				seg_kind = $urandom_range(0, 2);
			roll = $urandom_range(0, 99);
			if (roll < 3)
				kind = REQ_UNUSED;
			else if (seg_kind == 0)
				kind = (roll < 75) ? REQ_INSERT : (roll < 90) ? REQ_GET : REQ_REMOVE;
			else if (seg_kind == 1)
				kind = (roll < 20) ? REQ_INSERT : (roll < 40) ? REQ_GET : REQ_REMOVE;
			else
				kind = (roll < 40) ? REQ_INSERT : (roll < 70) ? REQ_GET : REQ_REMOVE;
			queue_request(kind, pick_position(kind), pick_word());
		end
	end

	// Driver: holds a beat until it is taken, then idles for a drawn gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				awaited_rsp_q.push_back(list_apply(in_data));
				accepted_cnt++;
			end
			if (in_valid && !in_ready) begin
				// Beat not yet taken: keep it as it is.
			end else if (drv_idle > 0) begin
				drv_idle--;
				in_valid <= 1'b0;
			end else if (request_q.size() > 0) begin
				in_data <= request_q.pop_front();
				in_valid <= 1'b1;
				if (drv_calm > 0) begin
					drv_calm--;
					drv_idle = 0;
				end else begin
					drv_idle = $urandom_range(0, MAX_IDLE);
					if ($urandom_range(0, 15) == 0)
						drv_calm = $urandom_range(20, 60);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each response beat, then stalls for a drawn gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_rsp_q.size() == 0) begin
					report_mismatch("response beat with nothing awaited, status",
						32'(out_data.status), 32'h0);
				end else begin
					rsp_t want;
					want = awaited_rsp_q.pop_front();
					if (out_data.status !== want.status)
						report_mismatch("status", 32'(out_data.status),
							32'(want.status));
					if (out_data.word_out !== want.word_out)
						report_mismatch("word_out", out_data.word_out, want.word_out);
					if (out_data.entry_count !== want.entry_count)
						report_mismatch("entry_count", 32'(out_data.entry_count),
							32'(want.entry_count));
					if (out_data.is_empty !== want.is_empty)
						report_mismatch("is_empty", 32'(out_data.is_empty),
							32'(want.is_empty));
					status_seen[want.status]++;
					checked_cnt++;
				end
				if (mon_calm > 0) begin
					mon_calm--;
					mon_idle = 0;
				end else begin
					mon_idle = $urandom_range(0, MAX_IDLE);
					if ($urandom_range(0, 15) == 0)
						mon_calm = $urandom_range(20, 60);
				end
			end
			if (mon_idle > 0) begin
				mon_idle--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d responses outstanding",
				cycle_cnt, awaited_rsp_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() > 0 || in_valid)
			@(posedge clk);
		while (awaited_rsp_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (awaited_rsp_q.size() > 0)
			report_mismatch("responses never returned", awaited_rsp_q.size(), 32'h0);

		$display("Ran %0d requests, checked %0d responses; list reached %0d of %0d entries.",
			accepted_cnt, checked_cnt, peak_len, LIST_CAP);
		$display("Responses: %0d ok, %0d out of range, %0d full; %0d mismatches.",
			status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL], err_cnt);
		if (err_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/indexed_list_store_core.sv
verif/tb_top.sv
